// File: sv/btpc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the barometric compensation block.
// No dependencies; the top level, the multiplier and the divider import this package.
package btpc_pkg;

    localparam int unsigned DW = 64;

    typedef logic signed [DW-1:0] s64_t;
    typedef logic [DW-1:0] u64_t;

    typedef enum logic [2:0] {
        REG_AC1    = 3'd0,
        REG_AC2    = 3'd1,
        REG_AC3    = 3'd2,
        REG_AC4    = 3'd3,
        REG_AC5    = 3'd4,
        REG_AC6    = 3'd5,
        REG_B1_B2  = 3'd6,
        REG_MC_MD  = 3'd7
    } reg_idx_t;

    localparam s64_t B6_OFFSET   = 64'sd4000;
    localparam s64_t B7_SCALE    = 64'sd50000;
    localparam s64_t B4_OFFSET   = 64'sd32768;
    localparam s64_t P_SQ_COEF   = 64'sd3038;
    localparam s64_t P_LIN_COEF  = -64'sd7357;
    localparam s64_t P_OFFSET    = 64'sd3791;
    localparam s64_t ROUND_T     = 64'sd8;
    localparam s64_t ROUND_B     = 64'sd2;
    localparam u64_t B7_LIMIT    = 64'h0000_0000_8000_0000;

    // Signed division by 2**k, truncating toward zero.
    function automatic s64_t sdiv_pow2(input s64_t x, input int unsigned k);
        s64_t bias;
        bias = x[DW-1] ? ((s64_t'(1) <<< k) - s64_t'(1)) : '0;
        return (x + bias) >>> k;
    endfunction

    function automatic u64_t abs64(input s64_t x);
        return x[DW-1] ? u64_t'(-x) : u64_t'(x);
    endfunction

endpackage

// File: sv/baro_temp_pressure_compensate_top.sv
`timescale 1ns / 1ps
// Barometric temperature and pressure compensation with APB calibration registers.
// Depends on btpc_pkg, btpc_mul and btpc_div.
// Temperature takes one serial multiplication and one division; pressure takes ten serial
// multiplications and one division. A zero divisor ends the reading early. One reading
// at a time; the next is taken once its result is registered. Reset returns the FSM to
// idle and clears the calibration registers, the stored B5 and the result valid flag.
module baro_temp_pressure_compensate_top import btpc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [23:0] s_raw_reading,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [31:0] m_result_value,
    output logic        m_div_error,
    output logic        m_result_mode
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_T_X1, ST_T_X2, ST_P_SQ, ST_P_X1, ST_P_X2, ST_P_X1B, ST_P_X2B,
        ST_P_B4, ST_P_B7, ST_P_DIV, ST_P_Q2, ST_P_Q3, ST_P_Q4, ST_OUT
    } state_t;

    state_t      state_reg;
    logic [15:0] ac1_reg, ac2_reg, ac3_reg, ac4_reg, ac5_reg, ac6_reg;
    logic [31:0] b1_b2_reg, mc_md_reg;
    logic [31:0] last_b5_reg;
    logic        mode_reg;
    logic [15:0] up_reg;
    s64_t        x1_reg, b6_reg, sq_reg, acc_reg, b3_reg, p_reg, res_reg;
    u64_t        b4_reg;
    logic        neg_reg, post_reg, err_reg;
    logic        mul_start_reg, div_start_reg;
    s64_t        mul_a_reg, mul_b_reg;
    u64_t        div_a_reg, div_b_reg;
    logic        m_valid_reg, m_div_error_reg, m_result_mode_reg;
    logic [31:0] m_result_value_reg;

    logic        mul_done, div_done;
    s64_t        mul_p;
    u64_t        div_q;
    s64_t        ac1_s, ac2_s, ac3_s, b1_s, b2_s, mc_s, md_s;
    s64_t        x1_t, den_t, num_t, x2_t, b5_t, b6_t, b3_t, x3b_t, b4_t, pu_t, tail_t;
    logic        cfg_wr;

    btpc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .op_a    (mul_a_reg),
        .op_b    (mul_b_reg),
        .done    (mul_done),
        .product (mul_p)
    );

    btpc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (div_a_reg),
        .divisor  (div_b_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb begin
        ac1_s  = s64_t'(signed'(ac1_reg));
        ac2_s  = s64_t'(signed'(ac2_reg));
        ac3_s  = s64_t'(signed'(ac3_reg));
        b1_s   = s64_t'(signed'(b1_b2_reg[31:16]));
        b2_s   = s64_t'(signed'(b1_b2_reg[15:0]));
        mc_s   = s64_t'(signed'(mc_md_reg[31:16]));
        md_s   = s64_t'(signed'(mc_md_reg[15:0]));
        x1_t   = sdiv_pow2(mul_p, 15);
        den_t  = x1_t + md_s;
        num_t  = mc_s <<< 11;
        x2_t   = neg_reg ? -s64_t'(div_q) : s64_t'(div_q);
        b5_t   = x1_reg + x2_t;
        b6_t   = s64_t'(signed'(last_b5_reg)) - B6_OFFSET;
        b3_t   = sdiv_pow2((ac1_s <<< 2) + acc_reg + sdiv_pow2(mul_p, 11) + ROUND_B, 2);
        x3b_t  = sdiv_pow2(acc_reg + sdiv_pow2(mul_p, 16) + ROUND_B, 2);
        b4_t   = s64_t'({15'd0, mul_p[DW-1:15]});
        pu_t   = post_reg ? s64_t'({div_q[DW-2:0], 1'b0}) : s64_t'(div_q);
        tail_t = p_reg + sdiv_pow2(acc_reg + sdiv_pow2(mul_p, 16) + P_OFFSET, 4);
    end

    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
            last_b5_reg   <= '0;
            ac1_reg       <= '0;
            ac2_reg       <= '0;
            ac3_reg       <= '0;
            ac4_reg       <= '0;
            ac5_reg       <= '0;
            ac6_reg       <= '0;
            b1_b2_reg     <= '0;
            mc_md_reg     <= '0;
        end else begin
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr) begin
                unique case (reg_idx_t'(paddr[4:2]))
                    REG_AC1:   ac1_reg   <= pwdata[15:0];
                    REG_AC2:   ac2_reg   <= pwdata[15:0];
                    REG_AC3:   ac3_reg   <= pwdata[15:0];
                    REG_AC4:   ac4_reg   <= pwdata[15:0];
                    REG_AC5:   ac5_reg   <= pwdata[15:0];
                    REG_AC6:   ac6_reg   <= pwdata[15:0];
                    REG_B1_B2: b1_b2_reg <= pwdata;
                    REG_MC_MD: mc_md_reg <= pwdata;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        mode_reg      <= s_mode;
                        up_reg        <= s_raw_reading[23:8];
                        err_reg       <= 1'b0;
                        res_reg       <= '0;
                        mul_start_reg <= 1'b1;
                        if (!s_mode) begin
                            mul_a_reg <= s64_t'({48'd0, s_raw_reading[15:0]})
                                         - s64_t'({48'd0, ac6_reg});
                            mul_b_reg <= s64_t'({48'd0, ac5_reg});
                            state_reg <= ST_T_X1;
                        end else begin
                            b6_reg    <= b6_t;
                            mul_a_reg <= b6_t;
                            mul_b_reg <= b6_t;
                            state_reg <= ST_P_SQ;
                        end
                    end
                end
                ST_T_X1: begin
                    if (mul_done) begin
                        x1_reg <= x1_t;
                        if (den_t == '0) begin
                            err_reg   <= 1'b1;
                            state_reg <= ST_OUT;
                        end else begin
                            div_a_reg     <= abs64(num_t);
                            div_b_reg     <= abs64(den_t);
                            neg_reg       <= num_t[DW-1] ^ den_t[DW-1];
                            div_start_reg <= 1'b1;
                            state_reg     <= ST_T_X2;
                        end
                    end
                end
                ST_T_X2: begin
                    if (div_done) begin
                        res_reg     <= sdiv_pow2(b5_t + ROUND_T, 4);
                        last_b5_reg <= b5_t[31:0];
                        state_reg   <= ST_OUT;
                    end
                end
                ST_P_SQ: begin
                    if (mul_done) begin
                        sq_reg        <= sdiv_pow2(mul_p, 12);
                        mul_a_reg     <= sdiv_pow2(mul_p, 12);
                        mul_b_reg     <= b2_s;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_P_X1;
                    end
                end
                ST_P_X1: begin
                    if (mul_done) begin
                        acc_reg       <= sdiv_pow2(mul_p, 11);
                        mul_a_reg     <= b6_reg;
                        mul_b_reg     <= ac2_s;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_P_X2;
                    end
                end
                ST_P_X2: begin
                    if (mul_done) begin
                        b3_reg        <= b3_t;
                        mul_a_reg     <= b6_reg;
                        mul_b_reg     <= ac3_s;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_P_X1B;
                    end
                end
                ST_P_X1B: begin
                    if (mul_done) begin
                        acc_reg       <= sdiv_pow2(mul_p, 13);
                        mul_a_reg     <= sq_reg;
                        mul_b_reg     <= b1_s;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_P_X2B;
                    end
                end
                ST_P_X2B: begin
                    if (mul_done) begin
                        mul_a_reg     <= x3b_t + B4_OFFSET;
                        mul_b_reg     <= s64_t'({48'd0, ac4_reg});
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_P_B4;
                    end
                end
                ST_P_B4: begin
                    if (mul_done) begin
                        if (b4_t == '0) begin
                            err_reg   <= 1'b1;
                            state_reg <= ST_OUT;
                        end else begin
                            b4_reg        <= u64_t'(b4_t);
                            mul_a_reg     <= s64_t'({48'd0, up_reg}) - b3_reg;
                            mul_b_reg     <= B7_SCALE;
                            mul_start_reg <= 1'b1;
                            state_reg     <= ST_P_B7;
                        end
                    end
                end
                ST_P_B7: begin
                    if (mul_done) begin
                        if (u64_t'(mul_p) < B7_LIMIT) begin
                            div_a_reg <= {mul_p[DW-2:0], 1'b0};
                            post_reg  <= 1'b0;
                        end else begin
                            div_a_reg <= u64_t'(mul_p);
                            post_reg  <= 1'b1;
                        end
                        div_b_reg     <= b4_reg;
                        div_start_reg <= 1'b1;
                        state_reg     <= ST_P_DIV;
                    end
                end
                ST_P_DIV: begin
                    if (div_done) begin
                        p_reg         <= pu_t;
                        mul_a_reg     <= sdiv_pow2(pu_t, 8);
                        mul_b_reg     <= sdiv_pow2(pu_t, 8);
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_P_Q2;
                    end
                end
                ST_P_Q2: begin
                    if (mul_done) begin
                        mul_a_reg     <= mul_p;
                        mul_b_reg     <= P_SQ_COEF;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_P_Q3;
                    end
                end
                ST_P_Q3: begin
                    if (mul_done) begin
                        acc_reg       <= sdiv_pow2(mul_p, 16);
                        mul_a_reg     <= p_reg;
                        mul_b_reg     <= P_LIN_COEF;
                        mul_start_reg <= 1'b1;
                        state_reg     <= ST_P_Q4;
                    end
                end
                ST_P_Q4: begin
                    if (mul_done) begin
                        res_reg   <= tail_t;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg        <= 1'b1;
                        m_result_value_reg <= err_reg ? 32'd0 : res_reg[31:0];
                        m_div_error_reg    <= err_reg;
                        m_result_mode_reg  <= mode_reg;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx_t'(paddr[4:2]))
            REG_AC1:   prdata = {16'd0, ac1_reg};
            REG_AC2:   prdata = {16'd0, ac2_reg};
            REG_AC3:   prdata = {16'd0, ac3_reg};
            REG_AC4:   prdata = {16'd0, ac4_reg};
            REG_AC5:   prdata = {16'd0, ac5_reg};
            REG_AC6:   prdata = {16'd0, ac6_reg};
            REG_B1_B2: prdata = b1_b2_reg;
            REG_MC_MD: prdata = mc_md_reg;
        endcase
    end

    assign pready         = 1'b1;
    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_result_value = signed'(m_result_value_reg);
    assign m_div_error    = m_div_error_reg;
    assign m_result_mode  = m_result_mode_reg;

endmodule

// File: sv/btpc_mul.sv
`timescale 1ns / 1ps
// Bit-serial multiplier giving the low 64 bits of a product, one bit per cycle.
// Depends on btpc_pkg.
module btpc_mul import btpc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic start,
    input  s64_t op_a,
    input  s64_t op_b,
    output logic done,
    output s64_t product
);

    u64_t a_reg;
    u64_t b_reg;
    u64_t acc_reg;
    logic busy_reg;
    logic done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                acc_reg  <= '0;
                if (op_b[DW-1]) begin
                    a_reg <= u64_t'(-op_a);
                    b_reg <= u64_t'(-op_b);
                end else begin
                    a_reg <= u64_t'(op_a);
                    b_reg <= u64_t'(op_b);
                end
            end else if (busy_reg) begin
                if (b_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    if (b_reg[0]) begin
                        acc_reg <= acc_reg + a_reg;
                    end
                    a_reg <= {a_reg[DW-2:0], 1'b0};
                    b_reg <= {1'b0, b_reg[DW-1:1]};
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = s64_t'(acc_reg);

endmodule

// File: sv/btpc_div.sv
`timescale 1ns / 1ps
// Restoring unsigned 64-bit divider producing one quotient bit per cycle.
// Depends on btpc_pkg.
module btpc_div import btpc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic start,
    input  u64_t dividend,
    input  u64_t divisor,
    output logic done,
    output u64_t quotient
);

    u64_t        rem_reg;
    u64_t        quo_reg;
    u64_t        dsr_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [DW:0] shifted;
    logic [DW:0] diff;

    always_comb begin
        shifted = {rem_reg, quo_reg[DW-1]};
        diff    = shifted - {1'b0, dsr_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dsr_reg  <= divisor;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (!diff[DW]) begin
                    rem_reg <= diff[DW-1:0];
                    quo_reg <= {quo_reg[DW-2:0], 1'b1};
                end else begin
                    rem_reg <= shifted[DW-1:0];
                    quo_reg <= {quo_reg[DW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: sv/btpc_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the compensation top level, attached by bind.
// Depends only on the top level's ports.
module btpc_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic signed [31:0] m_result_value,
    input logic        m_div_error,
    input logic        m_result_mode
);

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_div_error |-> m_result_value == 32'sd0)
        else $error("Division error reported with a nonzero value.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("Input ready stayed high after a transfer.");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid after reset.");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_value)
            && $stable(m_result_mode))
        else $error("Stalled result changed.");

endmodule

bind baro_temp_pressure_compensate_top btpc_chk u_btpc_chk (.*);
